// ===== design/keyboard_controller_with_key_queue_defines.svh =====
// Assertion macros shared by the keyboard controller modules.
// Every module that uses them has ports named clk and rst_n.
`ifndef KEYBOARD_CONTROLLER_WITH_KEY_QUEUE_DEFINES_SVH
`define KEYBOARD_CONTROLLER_WITH_KEY_QUEUE_DEFINES_SVH

// Checks a plain condition at every clock edge outside reset.
`define KBDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that one condition leads to another in the same cycle.
`define KBDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that one condition leads to another in the next cycle.
`define KBDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kbdq_pkg.sv =====
`default_nettype none

package kbdq_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int KEY_SPACE_DEF   = 256;

  localparam logic [15:0] CMD_CLEAR  = 16'd0;
  localparam logic [15:0] CMD_POP    = 16'd1;
  localparam logic [15:0] CMD_QUERY  = 16'd2;
  localparam logic [15:0] CMD_SETMSG = 16'd3;

  localparam logic MODE_KEY = 1'b0;

  typedef struct packed {
    logic        mode;
    logic [7:0]  key_code;
    logic        key_down;
    logic [15:0] cpu_reg_a;
    logic [15:0] cpu_reg_b;
  } in_item_t;

  typedef struct packed {
    logic        write_c;
    logic [15:0] c_value;
    logic        raise_irq;
    logic [15:0] irq_message;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP,
    ST_FULL
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== design/kbdq_ctrl.sv =====
`default_nettype none
`include "keyboard_controller_with_key_queue_defines.svh"

module kbdq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kbdq_pkg::dp_cmd_t      cmd
);

  kbdq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kbdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kbdq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = kbdq_pkg::ST_EXEC;
      end
      kbdq_pkg::ST_EXEC: begin
        state_nxt = kbdq_pkg::ST_RESP;
      end
      kbdq_pkg::ST_RESP: begin
        if (in_valid) begin
          state_nxt = out_stall ? kbdq_pkg::ST_FULL : kbdq_pkg::ST_EXEC;
        end else if (!out_stall) begin
          state_nxt = kbdq_pkg::ST_IDLE;
        end
      end
      kbdq_pkg::ST_FULL: begin
        if (!out_stall) state_nxt = kbdq_pkg::ST_EXEC;
      end
      default: state_nxt = kbdq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      kbdq_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      kbdq_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      kbdq_pkg::ST_RESP: begin
        in_stall    = 1'b0;
        out_valid   = 1'b1;
        cmd.capture = in_valid;
      end
      kbdq_pkg::ST_FULL: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // One more item can be taken in while a result waits; it executes once that result is taken.
  `KBDQ_ASSERT_IMPL(a_no_exec_pending, out_valid, !cmd.exec, "item executed over pending result")
  `KBDQ_ASSERT_NEXT(a_exec_to_resp, cmd.exec, out_valid, "executed item gave no result")
  `KBDQ_ASSERT_NEXT(a_capture_exec, cmd.capture, cmd.exec || out_valid, "captured item lost")

endmodule

`default_nettype wire

// ===== design/kbdq_dp.sv =====
`default_nettype none

module kbdq_dp #(
  parameter int QUEUE_DEPTH = kbdq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_SPACE   = kbdq_pkg::KEY_SPACE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kbdq_pkg::dp_cmd_t   cmd,
  input  wire kbdq_pkg::in_item_t  in_data,
  output kbdq_pkg::out_item_t      out_data
);

  localparam int QW     = $clog2(QUEUE_DEPTH);
  localparam int KIDX_W = $clog2(KEY_SPACE);

  kbdq_pkg::in_item_t  it_r;
  kbdq_pkg::out_item_t res_r, res_nxt;

  logic [KEY_SPACE-1:0] pressed_r;
  logic [7:0]           queue_mem [QUEUE_DEPTH];
  logic [7:0]           rdata_r;
  logic                 pop_hit_r;
  logic [QW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [QW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [15:0]          msg_r, msg_nxt;

  logic [7:0]        lookup_code;
  logic [KIDX_W-1:0] kidx;
  logic              key_in_space;
  logic              key_bit;
  logic              is_key;
  logic              key_chg;
  logic              push;
  logic              pop;
  logic [QW-1:0]     wr_ptr_inc;
  logic [QW-1:0]     rd_ptr_inc;

  always_ff @(posedge clk) begin
    if (cmd.capture) it_r <= in_data;
  end

  // Key events look up their own code; a query looks up the low byte of B.
  assign is_key       = (it_r.mode == kbdq_pkg::MODE_KEY);
  assign lookup_code  = is_key ? it_r.key_code : it_r.cpu_reg_b[7:0];
  assign key_in_space = ({1'b0, lookup_code} < 9'(KEY_SPACE));
  assign kidx         = lookup_code[KIDX_W-1:0];
  assign key_bit      = key_in_space && pressed_r[kidx];
  assign key_chg      = is_key && key_in_space && (key_bit != it_r.key_down);
  assign push         = key_chg && !it_r.key_down;
  assign pop          = !is_key && (it_r.cpu_reg_a == kbdq_pkg::CMD_POP) &&
                        (rd_ptr_r != wr_ptr_r);

  assign wr_ptr_inc = (wr_ptr_r == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    res_nxt    = '0;
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    msg_nxt    = msg_r;
    if (is_key) begin
      if (key_chg && msg_r != 16'd0) begin
        res_nxt.raise_irq   = 1'b1;
        res_nxt.irq_message = msg_r;
      end
      if (push) wr_ptr_nxt = wr_ptr_inc;
    end else begin
      case (it_r.cpu_reg_a)
        kbdq_pkg::CMD_CLEAR: begin
          rd_ptr_nxt = wr_ptr_r;
        end
        kbdq_pkg::CMD_POP: begin
          res_nxt.write_c = 1'b1;
          if (pop) rd_ptr_nxt = rd_ptr_inc;
        end
        kbdq_pkg::CMD_QUERY: begin
          res_nxt.write_c = 1'b1;
          res_nxt.c_value = 16'(key_bit);
        end
        kbdq_pkg::CMD_SETMSG: begin
          msg_nxt = it_r.cpu_reg_b;
        end
        default: begin
          res_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= '0;
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      msg_r     <= '0;
    end else if (cmd.exec) begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      msg_r    <= msg_nxt;
      if (key_chg) pressed_r[kidx] <= it_r.key_down;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r     <= res_nxt;
      pop_hit_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push) queue_mem[wr_ptr_r] <= it_r.key_code;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && pop) rdata_r <= queue_mem[rd_ptr_r];
  end

  always_comb begin
    out_data = res_r;
    if (pop_hit_r) out_data.c_value = {8'd0, rdata_r};
  end

endmodule

`default_nettype wire

// ===== design/keyboard_controller_with_key_queue.sv =====
// After an input transfer the EXEC state updates the key table and queue, and the
// RESP state then presents the result. One further item can transfer in while a
// result is offered; it executes only after that result has transferred out.
// Reset (synchronous, active low) clears all key bits, both queue pointers and the
// interrupt message; queue contents are not cleared and need no clearing pass.
`default_nettype none
`include "keyboard_controller_with_key_queue_defines.svh"

module keyboard_controller_with_key_queue #(
  parameter int QUEUE_DEPTH = kbdq_pkg::QUEUE_DEPTH_DEF,
  parameter int KEY_SPACE   = kbdq_pkg::KEY_SPACE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire kbdq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output kbdq_pkg::out_item_t      out_data
);

  kbdq_pkg::dp_cmd_t cmd;

  kbdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  kbdq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_SPACE   (KEY_SPACE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // A result comes either from a key event or from a command, never both.
  `KBDQ_ASSERT(a_irq_xor_c, !(out_valid && out_data.write_c && out_data.raise_irq),
    "irq and C write together")
  `KBDQ_ASSERT_IMPL(a_irq_msg, out_valid && out_data.raise_irq,
    out_data.irq_message != 16'd0, "irq with zero message")

endmodule

`default_nettype wire
